@@ rtl/esc_pkg.sv @@
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants of the epoch-to-calendar converter
// Holds the payload structs, the microcode word layout, the opcode and
// condition codes, the microcode ROM and the cumulative-day table.
// ----------------------------------------------------------------------------
package esc_pkg;

  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic [15:0] second_fraction;
  } in_item_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [15:0] fraction_out;
    logic        out_of_range;
  } out_item_t;

  localparam logic [31:0] END_OF_RANGE = 32'd4102444800;
  localparam logic [11:0] FIRST_YEAR   = 12'd1970;
  localparam logic [11:0] LAST_YEAR    = 12'd2099;

  // Division by a constant: the dividend is shifted right by the power of two
  // in the divisor, multiplied by the rounded-up reciprocal of the odd part,
  // and the product is shifted right. Exact over each dividend's range.
  localparam logic [25:0] DAY_MAGIC  = 26'd50903317;  // 2^35 / 675, rounded up
  localparam logic [25:0] HOUR_MAGIC = 26'd9321;      // 2^21 / 225, rounded up
  localparam logic [25:0] MIN_MAGIC  = 26'd1093;      // 2^14 / 15, rounded up
  localparam logic [16:0] SECS_DAY   = 17'd86400;
  localparam logic [11:0] SECS_HOUR  = 12'd3600;
  localparam logic [5:0]  SECS_MIN   = 6'd60;

  // Opcodes.
  localparam logic [3:0] OP_WAIT_IN    = 4'd0;
  localparam logic [3:0] OP_MUL        = 4'd1;
  localparam logic [3:0] OP_QUOT       = 4'd2;
  localparam logic [3:0] OP_SAVE       = 4'd3;
  localparam logic [3:0] OP_YEAR_STEP  = 4'd4;
  localparam logic [3:0] OP_MONTH_STEP = 4'd5;
  localparam logic [3:0] OP_DAY_CALC   = 4'd6;
  localparam logic [3:0] OP_SATURATE   = 4'd7;
  localparam logic [3:0] OP_PUBLISH    = 4'd8;
  localparam logic [3:0] OP_NOP        = 4'd9;

  // Operand select: which division OP_MUL, OP_QUOT and OP_SAVE work on.
  localparam logic [1:0] SEL_DAY  = 2'd0;
  localparam logic [1:0] SEL_HOUR = 2'd1;
  localparam logic [1:0] SEL_MIN  = 2'd2;

  // Jump conditions.
  localparam logic [2:0] COND_NONE       = 3'd0;
  localparam logic [2:0] COND_ALWAYS     = 3'd1;
  localparam logic [2:0] COND_NO_INPUT   = 3'd2;
  localparam logic [2:0] COND_OOR        = 3'd3;
  localparam logic [2:0] COND_YEAR_MORE  = 3'd5;
  localparam logic [2:0] COND_MONTH_MORE = 3'd6;
  localparam logic [2:0] COND_OUT_BUSY   = 3'd7;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] sel;
    logic [2:0] cond;
    logic [3:0] target;
  } uword_t;

  localparam logic [3:0] PC_WAIT    = 4'd0;
  localparam logic [3:0] PC_YEAR    = 4'd10;
  localparam logic [3:0] PC_MONTH   = 4'd11;
  localparam logic [3:0] PC_SAT     = 4'd13;
  localparam logic [3:0] PC_PUBLISH = 4'd14;

  function automatic uword_t ucode(input logic [3:0] pc);
    uword_t w;
    unique case (pc)
      4'd0:  w = '{OP_WAIT_IN,    SEL_DAY,  COND_NO_INPUT,   PC_WAIT};
      4'd1:  w = '{OP_MUL,        SEL_DAY,  COND_OOR,        PC_SAT};
      4'd2:  w = '{OP_QUOT,       SEL_DAY,  COND_NONE,       PC_WAIT};
      4'd3:  w = '{OP_SAVE,       SEL_DAY,  COND_NONE,       PC_WAIT};
      4'd4:  w = '{OP_MUL,        SEL_HOUR, COND_NONE,       PC_WAIT};
      4'd5:  w = '{OP_QUOT,       SEL_HOUR, COND_NONE,       PC_WAIT};
      4'd6:  w = '{OP_SAVE,       SEL_HOUR, COND_NONE,       PC_WAIT};
      4'd7:  w = '{OP_MUL,        SEL_MIN,  COND_NONE,       PC_WAIT};
      4'd8:  w = '{OP_QUOT,       SEL_MIN,  COND_NONE,       PC_WAIT};
      4'd9:  w = '{OP_SAVE,       SEL_MIN,  COND_NONE,       PC_WAIT};
      4'd10: w = '{OP_YEAR_STEP,  SEL_DAY,  COND_YEAR_MORE,  PC_YEAR};
      4'd11: w = '{OP_MONTH_STEP, SEL_DAY,  COND_MONTH_MORE, PC_MONTH};
      4'd12: w = '{OP_DAY_CALC,   SEL_DAY,  COND_ALWAYS,     PC_PUBLISH};
      4'd13: w = '{OP_SATURATE,   SEL_DAY,  COND_NONE,       PC_WAIT};
      4'd14: w = '{OP_PUBLISH,    SEL_DAY,  COND_OUT_BUSY,   PC_PUBLISH};
      4'd15: w = '{OP_NOP,        SEL_DAY,  COND_ALWAYS,     PC_WAIT};
      default: w = '{OP_NOP,      SEL_DAY,  COND_ALWAYS,     PC_WAIT};
    endcase
    return w;
  endfunction

  // Days before the first of month idx (idx 0 is January).
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + 9'((leap && (idx >= 4'd2) && (idx <= 4'd11)) ? 1 : 0);
  endfunction

endpackage

@@ rtl/epoch_seconds_to_calendar_date.sv @@
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_date: seconds since 1970 to calendar date/time
// A small microcoded sequencer that converts epoch seconds into year, month,
// day, hour, minute and second, passing the fraction of a second through.
// ----------------------------------------------------------------------------
// Usage:
// An item beat (item_valid high, item_stall low) carries epoch seconds and a
// fraction of a second. Each item yields exactly one result beat on the
// result channel, in order. The block works on one item at a time: item_stall
// is low only while the sequencer waits at its first step.
// The year-stepping loop subtracts one year length per cycle, once for each
// whole year past 1970 (0..129), and the month scan moves on one month per
// cycle; each division by a day, an hour and a minute runs as a multiply, a
// quotient and a save step. An input at or after 2100 leaves the sequence
// after its first multiply and comes back saturated to 2099-12-31 23:59:59
// with out_of_range set. item_stall drops in the cycle after result_valid
// rises, once the closing no-op step has run.
// The result sits in an output register, so the next item is taken while a
// result still waits; a stalled receiver holds the sequencer at its publish
// step only once a second result is ready.
// Reset clears the step counter and the result valid flag.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_date
  import esc_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  localparam int FRAC_KEEP = (FRAC_BITS < 16) ? FRAC_BITS : 16;

  logic [3:0]           pc;
  logic [3:0]           pc_next;
  uword_t               uw;
  logic                 take;

  logic [31:0]          acc;
  logic [50:0]          prod;
  logic [31:0]          back;
  logic [15:0]          days;
  logic [11:0]          year;
  logic [3:0]           mi;
  logic [4:0]           day;
  logic [4:0]           hour;
  logic [5:0]           minute;
  logic [5:0]           second;
  logic [FRAC_KEEP-1:0] frac;
  logic                 oor;

  logic                 leap;
  logic [15:0]          year_len;
  logic                 year_more;
  logic                 month_more;
  logic                 out_busy;
  logic [8:0]           cum_prev;
  logic [15:0]          day_of_month;
  logic [24:0]          mul_a;
  logic [25:0]          mul_b;
  logic [15:0]          quo_day;
  logic [4:0]           quo_hr;
  logic [5:0]           quo_min;
  logic [31:0]          acc_less;

  assign uw       = ucode(pc);
  assign out_busy = result_valid && result_stall;

  // Within 1970..2099 the Gregorian rule and the every-fourth-year rule
  // agree (2000 is divisible by 400), so one test serves both.
  assign leap     = (year[1:0] == 2'b00);
  assign year_len = leap ? 16'd366 : 16'd365;
  assign year_more  = (year < LAST_YEAR) && (days >= year_len);
  assign month_more = (mi < 4'd12) && (days >= 16'(cum_days(leap, mi)));
  assign cum_prev   = cum_days(leap, 4'(mi - 4'd1));
  assign day_of_month = days - 16'(cum_prev) + 16'd1;

  // The remainder in acc shrinks below a day, then below an hour, so the
  // upper bits dropped for the later divisions are already zero.
  always_comb begin
    unique case (uw.sel)
      SEL_DAY: begin
        mul_a = acc[31:7];
        mul_b = DAY_MAGIC;
      end
      SEL_HOUR: begin
        mul_a = 25'(acc[16:4]);
        mul_b = HOUR_MAGIC;
      end
      default: begin
        mul_a = 25'(acc[11:2]);
        mul_b = MIN_MAGIC;
      end
    endcase
  end

  assign quo_day  = prod[50:35];
  assign quo_hr   = prod[25:21];
  assign quo_min  = prod[19:14];
  assign acc_less = acc - back;

  always_comb begin
    unique case (uw.cond)
      COND_NONE:       take = 1'b0;
      COND_ALWAYS:     take = 1'b1;
      COND_NO_INPUT:   take = !item_valid;
      COND_OOR:        take = oor;
      COND_YEAR_MORE:  take = year_more;
      COND_MONTH_MORE: take = month_more;
      COND_OUT_BUSY:   take = out_busy;
      default:         take = 1'b0;
    endcase
    pc_next = take ? uw.target : 4'(pc + 4'd1);
  end

  assign item_stall = (pc != PC_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  // Datapath driven by the current control word.
  always_ff @(posedge clk) begin
    unique case (uw.op)
      OP_WAIT_IN: begin
        if (item_valid) begin
          acc  <= item.epoch_seconds;
          frac <= item.second_fraction[FRAC_KEEP-1:0];
          oor  <= (item.epoch_seconds >= END_OF_RANGE);
        end
      end
      OP_MUL: begin
        prod <= 51'(mul_a) * 51'(mul_b);
      end
      OP_QUOT: begin
        unique case (uw.sel)
          SEL_DAY: begin
            days <= quo_day;
            year <= FIRST_YEAR;
            mi   <= 4'd1;
            back <= 32'(33'(quo_day) * 33'(SECS_DAY));
          end
          SEL_HOUR: begin
            hour <= quo_hr;
            back <= 32'(17'(quo_hr) * 17'(SECS_HOUR));
          end
          default: begin
            minute <= quo_min;
            back   <= 32'(12'(quo_min) * 12'(SECS_MIN));
          end
        endcase
      end
      OP_SAVE: begin
        acc <= acc_less;
        if (uw.sel == SEL_MIN) begin
          second <= acc_less[5:0];
        end
      end
      OP_YEAR_STEP: begin
        if (year_more) begin
          days <= days - year_len;
          year <= 12'(year + 12'd1);
        end
      end
      OP_MONTH_STEP: begin
        if (month_more) begin
          mi <= 4'(mi + 4'd1);
        end
      end
      OP_DAY_CALC: begin
        day <= day_of_month[4:0];
      end
      OP_SATURATE: begin
        year   <= LAST_YEAR;
        mi     <= 4'd12;
        day    <= 5'd31;
        hour   <= 5'd23;
        minute <= 6'd59;
        second <= 6'd59;
      end
      OP_PUBLISH: begin
        if (!out_busy) begin
          result.year         <= year;
          result.month        <= mi;
          result.day          <= day;
          result.hour         <= hour;
          result.minute       <= minute;
          result.second       <= second;
          result.fraction_out <= 16'(frac);
          result.out_of_range <= oor;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((uw.op == OP_PUBLISH) && !out_busy) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // An accepted item always starts the program at its second step.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (pc == 4'd1))
    else $error("sequencer did not start after an item beat");

  // Publishing with a free output register always raises result_valid.
  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    ((pc == PC_PUBLISH) && !out_busy) |=> result_valid)
    else $error("published result not marked valid");

  // A result waiting on a stalled receiver is never overwritten.
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> $stable(result))
    else $error("stalled result changed");

  // Every published date and time lies in its legal range.
  a_fields_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.month >= 4'd1 && result.month <= 4'd12 &&
                      result.day >= 5'd1 && result.day <= 5'd31 &&
                      result.hour <= 5'd23 && result.minute <= 6'd59 &&
                      result.second <= 6'd59 && result.year >= FIRST_YEAR &&
                      result.year <= LAST_YEAR))
    else $error("result field out of range");

  // Out-of-range results are saturated to the last year.
  a_oor_saturates: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.out_of_range) |-> (result.year == LAST_YEAR))
    else $error("out-of-range result not saturated");

endmodule

@@ bench/tb_epoch_seconds_to_calendar_date.sv @@
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_date: self-checking bench for the converter
// Drives epoch timestamps through the item channel and checks every result
// beat, in order, against typed-in results or a calendar model in this file.
// A short table of hand-picked timestamps comes first, followed by random
// ones aimed at year ends, late February and the end of 2099.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_date;
  timeunit 1ns;
  timeprecision 1ps;
  import esc_pkg::*;

  localparam int unsigned SECS_PER_DAY = 86400;
  localparam int DIR_ROWS     = 21;
  localparam int RANDOM_ITEMS = 730;
  localparam int GAP_PCT      = 7;

  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t known;
  } date_row_t;

  logic      clk;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  in_item_t  item;
  logic      result_valid;
  logic      result_stall;
  out_item_t result;

  bit        steady;
  int        fails = 0;
  int        n_results = 0;
  int        n_items = 0;
  int        n_past_2099 = 0;
  int        n_leap_days = 0;
  out_item_t pending_dates[$];
  date_row_t dir_rows [0:DIR_ROWS-1];

  epoch_seconds_to_calendar_date dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("[epoch_seconds_to_calendar_date] ERROR");
    $finish;
  end

  function automatic out_item_t stamp(int y, int mo, int d, int h, int mi, int s,
                                      logic [15:0] frac, logic oor);
    out_item_t r;
    r.year         = 12'(y);
    r.month        = 4'(mo);
    r.day          = 5'(d);
    r.hour         = 5'(h);
    r.minute       = 6'(mi);
    r.second       = 6'(s);
    r.fraction_out = frac;
    r.out_of_range = oor;
    return r;
  endfunction

  // Days of the year that pass before the first of month idx (0 is January).
  function automatic int unsigned days_before_month(bit leap, int idx);
    int unsigned base;
    case (idx)
      0:       base = 0;
      1:       base = 31;
      2:       base = 59;
      3:       base = 90;
      4:       base = 120;
      5:       base = 151;
      6:       base = 181;
      7:       base = 212;
      8:       base = 243;
      9:       base = 273;
      10:      base = 304;
      default: base = 334;
    endcase
    return base + ((leap && idx >= 2) ? 1 : 0);
  endfunction

  function automatic out_item_t to_calendar(in_item_t it);
    out_item_t   r;
    int unsigned days;
    int unsigned secs;
    int unsigned yr;
    int unsigned len;
    int          mo;
    bit          leap;
    if (it.epoch_seconds >= END_OF_RANGE) begin
      r = stamp(int'(LAST_YEAR), 12, 31, 23, 59, 59, it.second_fraction, 1'b1);
    end else begin
      days = it.epoch_seconds / SECS_PER_DAY;
      secs = it.epoch_seconds % SECS_PER_DAY;
      yr   = FIRST_YEAR;
      // Year stepping counts every fourth year from 1972 as 366 days long.
      while (yr < LAST_YEAR) begin
        len = ((yr - FIRST_YEAR) % 4 == 2) ? 366 : 365;
        if (days < len) break;
        days -= len;
        yr++;
      end
      leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
      mo = 1;
      while (mo < 12 && days >= days_before_month(leap, mo)) mo++;
      r = stamp(int'(yr), mo, int'(days - days_before_month(leap, mo - 1)) + 1,
                int'(secs / 3600), int'((secs % 3600) / 60), int'(secs % 60),
                it.second_fraction, 1'b0);
    end
    return r;
  endfunction

  function automatic logic [31:0] year_start(int y);
    int unsigned days;
    days = (y - int'(FIRST_YEAR)) * 365 + (y - int'(FIRST_YEAR) + 1) / 4;
    return days * SECS_PER_DAY;
  endfunction

  // Mostly in-range timestamps, weighted toward year turns and late February.
  function automatic in_item_t random_item();
    in_item_t it;
    int       pick;
    int       y;
    pick = $urandom_range(0, 99);
    it.second_fraction = 16'($urandom);
    if (pick < 10) begin
      it.epoch_seconds = $urandom_range(32'hFFFF_FFFF, END_OF_RANGE);
    end else if (pick < 35) begin
      y = $urandom_range(1971, 2100);
      it.epoch_seconds = year_start(y) - SECS_PER_DAY
                         + $urandom_range(0, 2 * SECS_PER_DAY - 1);
    end else if (pick < 55) begin
      y = $urandom_range(int'(FIRST_YEAR), int'(LAST_YEAR));
      it.epoch_seconds = year_start(y) + (56 + $urandom_range(0, 5)) * SECS_PER_DAY
                         + $urandom_range(0, SECS_PER_DAY - 1);
    end else begin
      it.epoch_seconds = $urandom_range(0, END_OF_RANGE - 1);
    end
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat with
  // item_valid still high, so a following beat can go out back to back.
  task automatic send_date(in_item_t it, logic typed, out_item_t known);
    out_item_t want;
    if (!steady && $urandom_range(0, 99) < GAP_PCT) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 200)) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    want = typed ? known : to_calendar(it);
    pending_dates.push_back(want);
    n_items++;
    if (want.out_of_range) n_past_2099++;
    if (!want.out_of_range && want.month == 4'd2 && want.day == 5'd29) n_leap_days++;
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    item_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst && !steady && $urandom_range(0, 999) < 10) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_dates.size() == 0) begin
        $error("result beat with no item pending: %p", result);
        fails++;
      end else begin
        want = pending_dates.pop_front();
        n_results++;
        if (result.year !== want.year) begin
          $error("year: expected %0d, got %0d", want.year, result.year);
          fails++;
        end
        if (result.month !== want.month) begin
          $error("month: expected %0d, got %0d", want.month, result.month);
          fails++;
        end
        if (result.day !== want.day) begin
          $error("day: expected %0d, got %0d", want.day, result.day);
          fails++;
        end
        if (result.hour !== want.hour) begin
          $error("hour: expected %0d, got %0d", want.hour, result.hour);
          fails++;
        end
        if (result.minute !== want.minute) begin
          $error("minute: expected %0d, got %0d", want.minute, result.minute);
          fails++;
        end
        if (result.second !== want.second) begin
          $error("second: expected %0d, got %0d", want.second, result.second);
          fails++;
        end
        if (result.fraction_out !== want.fraction_out) begin
          $error("fraction_out: expected %h, got %h", want.fraction_out,
                 result.fraction_out);
          fails++;
        end
        if (result.out_of_range !== want.out_of_range) begin
          $error("out_of_range: expected %b, got %b", want.out_of_range,
                 result.out_of_range);
          fails++;
        end
      end
    end
  end

  initial begin
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    steady     = 1'b0;

    // Rows with typed-in results are the epoch itself, day and year turns and
    // the end of the range; the rest are left to the model.
    dir_rows = '{
      '{'{32'd0,          16'h0000}, 1'b1, stamp(1970,  1,  1,  0,  0,  0, 16'h0000, 1'b0)},
      '{'{32'd86399,      16'hFFFF}, 1'b1, stamp(1970,  1,  1, 23, 59, 59, 16'hFFFF, 1'b0)},
      '{'{32'd86400,      16'h0001}, 1'b1, stamp(1970,  1,  2,  0,  0,  0, 16'h0001, 1'b0)},
      '{'{32'd31535999,   16'h8000}, 1'b1, stamp(1970, 12, 31, 23, 59, 59, 16'h8000, 1'b0)},
      '{'{32'd31536000,   16'h7FFF}, 1'b1, stamp(1971,  1,  1,  0,  0,  0, 16'h7FFF, 1'b0)},
      '{'{32'd4102444799, 16'h0000}, 1'b1, stamp(2099, 12, 31, 23, 59, 59, 16'h0000, 1'b0)},
      '{'{32'd4102444800, 16'h8000}, 1'b1, stamp(2099, 12, 31, 23, 59, 59, 16'h8000, 1'b1)},
      '{'{32'hFFFF_FFFF,  16'hFFFF}, 1'b1, stamp(2099, 12, 31, 23, 59, 59, 16'hFFFF, 1'b1)},
      '{'{32'd2678399,    16'h0F0F}, 1'b0, '0},  // end of January 1970
      '{'{32'd68169600,   16'hAAAA}, 1'b0, '0},  // first step-leap day, 1972
      '{'{32'd68256000,   16'h5555}, 1'b0, '0},
      '{'{32'd946684799,  16'h1234}, 1'b0, '0},
      '{'{32'd951782400,  16'hF0F0}, 1'b0, '0},  // leap day of a century year
      '{'{32'd2147483647, 16'h00FF}, 1'b0, '0},  // signed 32-bit rollover
      '{'{32'd2147483648, 16'hFF00}, 1'b0, '0},
      '{'{32'd4070908799, 16'h3C3C}, 1'b0, '0},
      '{'{32'd4070908800, 16'hC3C3}, 1'b0, '0},
      '{'{32'd1234567890, 16'h9876}, 1'b0, '0},
      '{'{32'd3000000000, 16'h6789}, 1'b0, '0},
      '{'{32'd4000000000, 16'h1357}, 1'b0, '0},
      '{'{32'd4200000000, 16'hFACE}, 1'b0, '0}
    };

    repeat (12) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_date(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].known);
    end
    wait_all_results();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      steady = (k >= 300 && k < 450);
      if (k == 500) wait_all_results();
      send_date(random_item(), 1'b0, '0);
    end
    steady = 1'b0;
    wait_all_results();
    repeat (200) @(posedge clk);

    $display("Converted %0d timestamps with %0d results checked.", n_items, n_results);
    $display("%0d lay past the end of 2099 and %0d fell on a February 29.",
             n_past_2099, n_leap_days);
    if (fails == 0) begin
      $display("[epoch_seconds_to_calendar_date] OK");
    end else begin
      $display("[epoch_seconds_to_calendar_date] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/esc_pkg.sv
rtl/epoch_seconds_to_calendar_date.sv
bench/tb_epoch_seconds_to_calendar_date.sv
